FILE: rtl/jes_pkg.sv
package jes_pkg;

  localparam int MATRIX_SIZE_DEF   = 4;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int VAL_W             = 32;
  localparam int IDX_W             = 3;
  localparam int THR_W             = 32;
  localparam int LIM_W             = 8;
  localparam int CFG_DATA_W        = 32;
  localparam int CFG_IDX_W         = 1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LIMIT = 1'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd1;
  localparam logic [LIM_W-1:0] SWEEP_LIMIT_RESET = 8'd16;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/jacobi_eigen_solver.sv
// Cyclic Jacobi eigen-solver for a small symmetric matrix in signed fixed point. Entries are
// loaded one item per cycle while busy is low; the item with last_entry set starts a solve, and
// busy then stays high until the last result has been shown. Each sweep first sums the squares of
// the below-diagonal entries through the shared multiplier and stops when twice that sum is at most
// the threshold or the sweep limit is reached. Every rotation runs on one shared 34x34 multiplier
// and one shared bit-serial divider / square-root unit, which computes two square roots and three
// divisions. Each row update uses four multiplies; the two pivot rows of the matrix skip them. A
// pair with a zero off-diagonal entry is skipped, and one sweep holds N*(N-1)/2 pairs. Results then
// leave one per cycle, N*N eigenvector elements in row-major order followed by N eigenvalues, each
// marked by out_valid for exactly one cycle; the receiver cannot stall them, and last_result marks
// the final one. Configuration must be written only while busy is low; the block itself does not
// enforce it.
module jacobi_eigen_solver #(
  parameter int MATRIX_SIZE   = jes_pkg::MATRIX_SIZE_DEF,
  parameter int FRACTION_BITS = jes_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [jes_pkg::IDX_W-1:0]         in_entry_row,
  input  logic [jes_pkg::IDX_W-1:0]         in_entry_col,
  input  logic signed [jes_pkg::VAL_W-1:0]  in_entry_value,
  input  logic                              in_last_entry,
  input  logic                              cfg_we,
  input  logic [jes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jes_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  output logic                              out_result_kind,
  output logic [jes_pkg::IDX_W-1:0]         out_result_row,
  output logic [jes_pkg::IDX_W-1:0]         out_result_col,
  output logic signed [jes_pkg::VAL_W-1:0]  out_result_value,
  output logic                              out_converged,
  output logic                              out_last_result
);

  localparam int N  = MATRIX_SIZE;
  localparam int NN = N * N;
  localparam int F  = FRACTION_BITS;
  localparam int AW = $clog2(NN);
  localparam int IW = jes_pkg::IDX_W;

  typedef enum logic [4:0] {
    S_IDLE, S_SUM_RD, S_SUM_ACC, S_CHECK, S_ROT_RD, S_ROT_PREP, S_SQ1, S_SQ1_ADD,
    S_R1, S_DIV_T, S_TT, S_R2, S_DIV_C, S_MUL_S, S_DIV_TAU, S_DIAG, S_DIAG2,
    S_K_RD, S_K_M1, S_K_M2, S_K_M3, S_K_M4, S_K_WR, S_NEXT_PAIR, S_OUT
  } state_t;

  state_t state_r;

  // Stores: simple arrays; reads are registered by the sequencer.
  logic signed [31:0] mat_r [NN];
  logic signed [31:0] vec_r [NN];

  logic [31:0]        thr_r;
  logic [7:0]         lim_r;
  logic [7:0]         sweep_r;
  logic [IW-1:0]      p_r, q_r, k_r, i_r, j_r;
  logic               kvec_r;     // row update pass on the vector store
  logic [AW:0]        out_cnt_r;
  logic               conv_r;
  logic [65:0]        sum_r;

  // Rotation operands and intermediates.
  logic signed [33:0] a_r, app_r, aqq_r;
  logic [33:0]        md_r, ma_r;
  logic [65:0]        acc_r;
  logic signed [33:0] t_r, c_r, s_r, tau_r;
  logic signed [33:0] kp_r, kq_r, x_r;
  logic signed [33:0] newp_r, newq_r;

  // Shared multiplier: 34x34 signed with rounding rescale option.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_raw;
  logic [67:0]        mul_mag;
  logic signed [66:0] mulq_res;
  logic [67:0]        mq_abs;
  always_comb begin
    mul_raw = mul_a * mul_b;
    mul_mag = mul_raw[67] ? 68'(-mul_raw) : mul_raw;
    mq_abs  = (mul_mag + (68'd1 << (F - 1))) >> F;
    mulq_res = mul_raw[67] ? -67'(mq_abs) : 67'(mq_abs);
  end

  // Shared bit-serial square root / divider (one bit per cycle).
  logic        du_go, du_sqrt, du_done;
  logic        du_go_nxt;
  logic [65:0] du_x, du_d, du_q;
  jes_divsqrt u_du (
    .clk(clk), .rst_n(rst_n), .go(du_go), .is_sqrt(du_sqrt),
    .x(du_x), .d(du_d), .done(du_done), .q(du_q)
  );

  // The unit is started for one cycle; done is only trusted once go has dropped.
  always_comb begin
    case (state_r)
      S_SQ1_ADD, S_TT, S_MUL_S: du_go_nxt = 1'b1;
      S_R1, S_R2:               du_go_nxt = !du_go && du_done;
      default:                  du_go_nxt = 1'b0;
    endcase
  end

  function automatic logic [AW-1:0] ix(input logic [IW-1:0] r, input logic [IW-1:0] c);
    ix = AW'(32'(r) * N + 32'(c));
  endfunction

  // Row updates (same formula for both stores).
  // newp = kp - mulq(s, kq + mulq(tau, kp)); newq = kq + mulq(s, kp - mulq(tau, kq))

  always_comb begin
    mul_a = s_r;
    mul_b = x_r;
    case (state_r)
      S_SUM_ACC: begin
        mul_a = kp_r; mul_b = kp_r;
      end
      S_SQ1:     begin mul_a = $signed(md_r); mul_b = $signed(md_r); end
      S_SQ1_ADD: begin mul_a = $signed(ma_r); mul_b = $signed(ma_r); end
      S_TT:      begin mul_a = t_r; mul_b = t_r; end
      S_MUL_S:   begin mul_a = t_r; mul_b = c_r; end
      S_DIAG, S_DIAG2: begin mul_a = t_r; mul_b = a_r; end
      S_K_M1:    begin mul_a = tau_r; mul_b = kp_r; end
      S_K_M2:    begin mul_a = s_r; mul_b = x_r; end
      S_K_M3:    begin mul_a = tau_r; mul_b = kq_r; end
      S_K_M4:    begin mul_a = s_r; mul_b = x_r; end
      default:   begin mul_a = s_r; mul_b = x_r; end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  logic [AW:0] last_idx;
  assign last_idx = (AW+1)'(NN + N - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      du_go     <= 1'b0;
      state_r   <= S_IDLE;
      thr_r     <= jes_pkg::THRESHOLD_RESET;
      lim_r     <= jes_pkg::SWEEP_LIMIT_RESET;
      sweep_r   <= '0;
      out_valid <= 1'b0;
      conv_r    <= 1'b0;
      out_cnt_r <= '0;
      for (int e = 0; e < NN; e++) begin
        vec_r[e] <= ((e % N) == (e / N)) ? 32'(1 << F) : 32'd0;
      end
    end else begin
      du_go     <= du_go_nxt;
      out_valid <= (state_r == S_OUT);
      if (cfg_we) begin
        if (cfg_index == jes_pkg::REG_THRESHOLD) thr_r <= cfg_data;
        else if (cfg_index == jes_pkg::REG_SWEEP_LIMIT) lim_r <= cfg_data[7:0];
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (32'(in_entry_row) < N && 32'(in_entry_col) < N) begin
              mat_r[ix(in_entry_row, in_entry_col)] <= in_entry_value;
            end
            if (in_last_entry) begin
              for (int e = 0; e < NN; e++) begin
                vec_r[e] <= ((e % N) == (e / N)) ? 32'(1 << F) : 32'd0;
              end
              sweep_r <= '0;
              sum_r   <= '0;
              i_r     <= IW'(1);
              j_r     <= '0;
              state_r <= S_SUM_RD;
            end
          end
        end
        S_SUM_RD: begin
          kp_r    <= 34'(mat_r[ix(i_r, j_r)]);
          state_r <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          sum_r <= sum_r + 66'(mul_mag >> F);
          if (32'(j_r) + 1 < 32'(i_r)) begin
            j_r <= j_r + 1'b1;
            state_r <= S_SUM_RD;
          end else if (32'(i_r) + 1 < N) begin
            i_r <= i_r + 1'b1;
            j_r <= '0;
            state_r <= S_SUM_RD;
          end else begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((sum_r << 1) <= 66'(thr_r)) begin
            conv_r <= 1'b1; out_cnt_r <= '0; i_r <= '0; j_r <= '0; state_r <= S_OUT;
          end else if (sweep_r >= lim_r) begin
            conv_r <= 1'b0; out_cnt_r <= '0; i_r <= '0; j_r <= '0; state_r <= S_OUT;
          end else begin
            p_r <= IW'(1); q_r <= '0; state_r <= S_ROT_RD;
          end
        end
        S_ROT_RD: begin
          a_r   <= 34'(mat_r[ix(p_r, q_r)]);
          app_r <= 34'(mat_r[ix(p_r, p_r)]);
          aqq_r <= 34'(mat_r[ix(q_r, q_r)]);
          state_r <= S_ROT_PREP;
        end
        S_ROT_PREP: begin
          if (a_r == 0) begin
            state_r <= S_NEXT_PAIR;
          end else begin
            logic signed [33:0] d;
            logic [33:0] md, ma;
            d  = aqq_r - app_r;
            md = d[33] ? 34'(-d) : d;
            ma = a_r[33] ? 34'(-(a_r <<< 1)) : 34'(a_r <<< 1);
            if ((md > ma ? md : ma) >= 34'h080000000) begin
              md = md >> 2; ma = ma >> 2;
            end
            md_r <= md; ma_r <= ma;
            state_r <= S_SQ1;
          end
        end
        S_SQ1: begin
          acc_r <= 66'(mul_raw);
          state_r <= S_SQ1_ADD;
        end
        S_SQ1_ADD: begin
          du_x <= acc_r + 66'(mul_raw); du_sqrt <= 1'b1;
          state_r <= S_R1;
        end
        S_R1: begin
          if (!du_go && du_done) begin
            du_x <= (66'(ma_r) << F) + 66'((md_r + 34'(du_q)) >> 1);
            du_d <= 66'(md_r + 34'(du_q));
            du_sqrt <= 1'b0; state_r <= S_DIV_T;
          end
        end
        S_DIV_T: begin
          if (!du_go && du_done) begin
            logic signed [33:0] d;
            d = aqq_r - app_r;
            if (d != 0 && (d[33] != a_r[33])) t_r <= -34'(du_q);
            else t_r <= 34'(du_q);
            state_r <= S_TT;
          end
        end
        S_TT: begin
          du_x <= 66'(mul_raw) + (66'd1 << (2 * F));
          du_sqrt <= 1'b1; state_r <= S_R2;
        end
        S_R2: begin
          if (!du_go && du_done) begin
            du_x <= (66'd1 << (2 * F)) + (du_q >> 1);
            du_d <= du_q; du_sqrt <= 1'b0; state_r <= S_DIV_C;
          end
        end
        S_DIV_C: begin
          if (!du_go && du_done) begin
            c_r <= 34'(du_q); state_r <= S_MUL_S;
          end
        end
        S_MUL_S: begin
          logic [33:0] sm, dd;
          sm = mulq_res[66] ? 34'(-mulq_res) : 34'(mulq_res);
          dd = 34'(1 << F) + c_r;
          s_r <= 34'(mulq_res);
          du_x <= (66'(sm) << F) + 66'(dd >> 1);
          du_d <= 66'(dd); du_sqrt <= 1'b0; state_r <= S_DIV_TAU;
        end
        S_DIV_TAU: begin
          if (!du_go && du_done) begin
            tau_r <= s_r[33] ? -34'(du_q) : 34'(du_q);
            state_r <= S_DIAG;
          end
        end
        S_DIAG: begin
          mat_r[ix(p_r, p_r)] <= jes_pkg::sat32(66'(app_r) - 66'(mulq_res));
          state_r <= S_DIAG2;
        end
        S_DIAG2: begin
          mat_r[ix(q_r, q_r)] <= jes_pkg::sat32(66'(aqq_r) + 66'(mulq_res));
          k_r <= '0; kvec_r <= 1'b0; state_r <= S_K_RD;
        end
        S_K_RD: begin
          if (!kvec_r && (k_r == p_r || k_r == q_r)) begin
            state_r <= S_K_WR;
          end else begin
            kp_r <= kvec_r ? 34'(vec_r[ix(k_r, p_r)]) : 34'(mat_r[ix(k_r, p_r)]);
            kq_r <= kvec_r ? 34'(vec_r[ix(k_r, q_r)]) : 34'(mat_r[ix(k_r, q_r)]);
            state_r <= S_K_M1;
          end
        end
        S_K_M1: begin x_r <= 34'(kq_r + 34'(mulq_res)); state_r <= S_K_M2; end
        S_K_M2: begin
          newp_r <= 34'(jes_pkg::sat32(66'(kp_r) - 66'(mulq_res)));
          state_r <= S_K_M3;
        end
        S_K_M3: begin x_r <= 34'(kp_r - 34'(mulq_res)); state_r <= S_K_M4; end
        S_K_M4: begin
          newq_r <= 34'(jes_pkg::sat32(66'(kq_r) + 66'(mulq_res)));
          state_r <= S_K_WR;
        end
        S_K_WR: begin
          if (!kvec_r) begin
            if (k_r != p_r && k_r != q_r) begin
              mat_r[ix(k_r, p_r)] <= newp_r[31:0];
              mat_r[ix(p_r, k_r)] <= newp_r[31:0];
              mat_r[ix(k_r, q_r)] <= newq_r[31:0];
              mat_r[ix(q_r, k_r)] <= newq_r[31:0];
            end
          end else begin
            vec_r[ix(k_r, p_r)] <= newp_r[31:0];
            vec_r[ix(k_r, q_r)] <= newq_r[31:0];
          end
          if (32'(k_r) + 1 < N) begin
            k_r <= k_r + 1'b1; state_r <= S_K_RD;
          end else if (!kvec_r) begin
            mat_r[ix(p_r, q_r)] <= '0;
            mat_r[ix(q_r, p_r)] <= '0;
            k_r <= '0; kvec_r <= 1'b1; state_r <= S_K_RD;
          end else begin
            state_r <= S_NEXT_PAIR;
          end
        end
        S_NEXT_PAIR: begin
          if (32'(q_r) + 1 < 32'(p_r)) begin
            q_r <= q_r + 1'b1; state_r <= S_ROT_RD;
          end else if (32'(p_r) + 1 < N) begin
            p_r <= p_r + 1'b1; q_r <= '0; state_r <= S_ROT_RD;
          end else begin
            sweep_r <= sweep_r + 1'b1;
            sum_r <= '0; i_r <= IW'(1); j_r <= '0; state_r <= S_SUM_RD;
          end
        end
        S_OUT: begin
          // i_r and j_r walk the vector store row by row, then i_r walks the diagonal.
          out_converged <= conv_r;
          out_last_result <= (out_cnt_r == last_idx);
          if (out_cnt_r < (AW+1)'(NN)) begin
            out_result_kind  <= 1'b0;
            out_result_row   <= i_r;
            out_result_col   <= j_r;
            out_result_value <= vec_r[ix(i_r, j_r)];
            if (32'(j_r) + 1 < N) begin
              j_r <= j_r + 1'b1;
            end else begin
              j_r <= '0;
              i_r <= (32'(i_r) + 1 < N) ? i_r + 1'b1 : '0;
            end
          end else begin
            out_result_kind  <= 1'b1;
            out_result_row   <= i_r;
            out_result_col   <= '0;
            out_result_value <= mat_r[ix(i_r, i_r)];
            i_r <= i_r + 1'b1;
          end
          if (out_cnt_r == last_idx) state_r <= S_IDLE;
          out_cnt_r <= out_cnt_r + 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/jes_divsqrt.sv
// Shared restoring unit: integer square root or unsigned division, one bit per cycle.
module jes_divsqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic        is_sqrt,
  input  logic [65:0] x,
  input  logic [65:0] d,
  output logic        done,
  output logic [65:0] q
);

  logic [67:0] rem_r;
  logic [65:0] num_r, den_r, q_r;
  logic [6:0]  cnt_r;
  logic        run_r, sq_r;
  logic [67:0] trial;
  logic [67:0] rem_sh;

  always_comb begin
    if (sq_r) begin
      rem_sh = {rem_r[65:0], num_r[65:64]};
      trial  = {q_r[65:0], 2'b01};
    end else begin
      rem_sh = {rem_r[66:0], num_r[65]};
      trial  = {2'b00, den_r};
    end
  end

  assign done = !run_r;
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (go) begin
      run_r <= 1'b1; sq_r <= is_sqrt; num_r <= x; den_r <= d;
      rem_r <= '0; q_r <= '0;
      cnt_r <= is_sqrt ? 7'd33 : 7'd66;
    end else if (run_r) begin
      if (rem_sh >= trial) begin
        rem_r <= rem_sh - trial; q_r <= {q_r[64:0], 1'b1};
      end else begin
        rem_r <= rem_sh; q_r <= {q_r[64:0], 1'b0};
      end
      num_r <= sq_r ? {num_r[63:0], 2'b00} : {num_r[64:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == 7'd1) run_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/jes_checker.sv
module jes_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_entry,
  input logic out_valid,
  input logic out_last_result
);

  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result && out_valid |-> !busy)
    else $error("busy after last result");

  a_valid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> busy)
    else $error("result outside a solve");

  a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_entry |=> busy)
    else $error("last entry did not start a solve");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

endmodule

bind jacobi_eigen_solver jes_checker u_jes_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_last_entry(in_last_entry),
  .out_valid(out_valid), .out_last_result(out_last_result)
);

FILE: sim/tb_jacobi_eigen_solver.sv
`timescale 1ns / 100ps

module tb_jacobi_eigen_solver;

  localparam int N = jes_pkg::MATRIX_SIZE_DEF;
  localparam int FB = jes_pkg::FRACTION_BITS_DEF;
  localparam int NN = N * N;
  localparam longint ONE_Q = longint'(1) << FB;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 250;

  // One matrix entry as it travels over the input channel.
  typedef struct {
    logic [jes_pkg::IDX_W-1:0] row;
    logic [jes_pkg::IDX_W-1:0] col;
    logic signed [jes_pkg::VAL_W-1:0] value;
    logic last;
  } entry_t;

  // One eigenvector element or eigenvalue as the block should show it.
  typedef struct {
    logic kind;
    logic [jes_pkg::IDX_W-1:0] row;
    logic [jes_pkg::IDX_W-1:0] col;
    logic signed [jes_pkg::VAL_W-1:0] value;
    logic conv;
    logic last;
  } eigen_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [jes_pkg::IDX_W-1:0] in_entry_row;
  logic [jes_pkg::IDX_W-1:0] in_entry_col;
  logic signed [jes_pkg::VAL_W-1:0] in_entry_value;
  logic in_last_entry;
  logic cfg_we;
  logic [jes_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [jes_pkg::CFG_DATA_W-1:0] cfg_data;
  logic out_valid;
  logic out_result_kind;
  logic [jes_pkg::IDX_W-1:0] out_result_row;
  logic [jes_pkg::IDX_W-1:0] out_result_col;
  logic signed [jes_pkg::VAL_W-1:0] out_result_value;
  logic out_converged;
  logic out_last_result;

  jacobi_eigen_solver DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_entry_row(in_entry_row), .in_entry_col(in_entry_col),
    .in_entry_value(in_entry_value), .in_last_entry(in_last_entry),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_result_kind(out_result_kind),
    .out_result_row(out_result_row), .out_result_col(out_result_col),
    .out_result_value(out_result_value), .out_converged(out_converged),
    .out_last_result(out_last_result)
  );

  // Items waiting to be sent, and eigen results waiting to be seen.
  entry_t pending_entries[$];
  eigen_result_t expected_results[$];
  int error_count;
  int cycle_count;
  int random_sent;

  // Shadow copy of the solver state and its two registers.
  int shadow_matrix[NN];
  int shadow_vectors[NN];
  logic [jes_pkg::THR_W-1:0] shadow_threshold;
  logic [jes_pkg::LIM_W-1:0] shadow_sweep_limit;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint unsigned mag(longint a);
    return (a < 0) ? longint'(-a) : a;
  endfunction

  function automatic int sat_val(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Fixed-point product, rounded half away from zero.
  function automatic longint mul_fixed(longint a, longint b);
    longint unsigned m;
    longint unsigned r;
    m = mag(a) * mag(b);
    r = (m + (64'd1 << (FB - 1))) >> FB;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned off_diag_energy();
    longint unsigned sum;
    longint unsigned m;
    sum = 0;
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < r; c++) begin
        m = mag(shadow_matrix[r*N+c]);
        sum += (m * m) >> FB;
      end
    end
    return sum * 2;
  endfunction

  // One Jacobi rotation that zeroes the (p,q) pair, applied to both stores.
  task automatic rotate_pair(int p, int q);
    longint a, app, aqq, d, t, c, s, tau, kp, kq;
    longint unsigned md, ma, mx, r, den, num, tt, sq, dd, rr;
    int newp[N];
    int newq[N];
    a = shadow_matrix[p*N+q];
    app = shadow_matrix[p*N+p];
    aqq = shadow_matrix[q*N+q];
    if (a == 0) return;
    d = aqq - app;
    md = mag(d);
    ma = mag(a) * 2;
    mx = (md > ma) ? md : ma;
    if (mx >= (64'd1 << 31)) begin
      md = md >> 2;
      ma = ma >> 2;
    end
    r = int_sqrt(md * md + ma * ma);
    den = md + r;
    num = ma << FB;
    t = longint'((num + den / 2) / den);
    if (d != 0 && ((d < 0) != (a < 0))) t = -t;
    tt = longint'(t * t) + (64'd1 << (2 * FB));
    sq = int_sqrt(tt);
    c = longint'(((64'd1 << (2 * FB)) + sq / 2) / sq);
    s = mul_fixed(t, c);
    dd = ONE_Q + c;
    rr = ((mag(s) << FB) + dd / 2) / dd;
    tau = (s < 0) ? -longint'(rr) : longint'(rr);
    for (int k = 0; k < N; k++) begin
      if (k != p && k != q) begin
        kp = shadow_matrix[k*N+p];
        kq = shadow_matrix[k*N+q];
        newp[k] = sat_val(kp - mul_fixed(s, kq + mul_fixed(tau, kp)));
        newq[k] = sat_val(kq + mul_fixed(s, kp - mul_fixed(tau, kq)));
      end
    end
    shadow_matrix[p*N+q] = 0;
    shadow_matrix[q*N+p] = 0;
    shadow_matrix[p*N+p] = sat_val(app - mul_fixed(t, a));
    shadow_matrix[q*N+q] = sat_val(aqq + mul_fixed(t, a));
    for (int k = 0; k < N; k++) begin
      if (k != p && k != q) begin
        shadow_matrix[k*N+p] = newp[k];
        shadow_matrix[p*N+k] = newp[k];
        shadow_matrix[k*N+q] = newq[k];
        shadow_matrix[q*N+k] = newq[k];
      end
    end
    for (int k = 0; k < N; k++) begin
      kp = shadow_vectors[k*N+p];
      kq = shadow_vectors[k*N+q];
      newp[k] = sat_val(kp - mul_fixed(s, kq + mul_fixed(tau, kp)));
      newq[k] = sat_val(kq + mul_fixed(s, kp - mul_fixed(tau, kq)));
    end
    for (int k = 0; k < N; k++) begin
      shadow_vectors[k*N+p] = newp[k];
      shadow_vectors[k*N+q] = newq[k];
    end
  endtask

  // Store one accepted entry; on the last one, solve and queue every result.
  task automatic absorb_entry(entry_t e);
    eigen_result_t res;
    logic conv;
    int sweeps;
    if (e.row < N && e.col < N) shadow_matrix[e.row*N+e.col] = e.value;
    if (!e.last) return;
    for (int i = 0; i < NN; i++) shadow_vectors[i] = ((i % N) == (i / N)) ? int'(ONE_Q) : 0;
    sweeps = 0;
    forever begin
      if (off_diag_energy() <= longint'(shadow_threshold)) begin
        conv = 1'b1;
        break;
      end
      if (sweeps >= shadow_sweep_limit) begin
        conv = 1'b0;
        break;
      end
      for (int p = 0; p < N; p++)
        for (int q = 0; q < p; q++)
          rotate_pair(p, q);
      sweeps++;
    end
    for (int i = 0; i < NN + N; i++) begin
      res.kind = (i >= NN);
      res.row = (i < NN) ? jes_pkg::IDX_W'(i / N) : jes_pkg::IDX_W'(i - NN);
      res.col = (i < NN) ? jes_pkg::IDX_W'(i % N) : '0;
      res.value = (i < NN) ? shadow_vectors[i] : shadow_matrix[(i-NN)*N+(i-NN)];
      res.conv = conv;
      res.last = (i == NN + N - 1);
      expected_results.push_back(res);
    end
  endtask

  // Driver. The item on the ports is taken at an edge where start is high and
  // busy is low; a held item stays put while busy is high. Gaps are mostly
  // short, now and then long, with bursts where no gap is inserted at all.
  int gap_left;
  bit burst_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
      burst_mode = 1'b0;
    end else if (start && busy) begin
      // The item is held until the block takes it.
    end else begin
      if (start) absorb_entry('{in_entry_row, in_entry_col, in_entry_value, in_last_entry});
      if ($urandom_range(0, 31) == 0) burst_mode = ~burst_mode;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_entries.size() != 0) begin
        entry_t e;
        e = pending_entries.pop_front();
        in_entry_row <= e.row;
        in_entry_col <= e.col;
        in_entry_value <= e.value;
        in_last_entry <= e.last;
        start <= 1'b1;
        if (!burst_mode)
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d row %0d col %0d value %0d",
               out_result_kind, out_result_row, out_result_col, out_result_value);
        error_count++;
      end else begin
        eigen_result_t x;
        x = expected_results.pop_front();
        if (out_result_kind !== x.kind) begin
          $error("result_kind: expected %0d, got %0d", x.kind, out_result_kind);
          error_count++;
        end
        if (out_result_row !== x.row) begin
          $error("result_row: expected %0d, got %0d", x.row, out_result_row);
          error_count++;
        end
        if (out_result_col !== x.col) begin
          $error("result_col: expected %0d, got %0d", x.col, out_result_col);
          error_count++;
        end
        if (out_result_value !== x.value) begin
          $error("result_value: expected %0d, got %0d", x.value, out_result_value);
          error_count++;
        end
        if (out_converged !== x.conv) begin
          $error("converged: expected %0d, got %0d", x.conv, out_converged);
          error_count++;
        end
        if (out_last_result !== x.last) begin
          $error("last_result: expected %0d, got %0d", x.last, out_last_result);
          error_count++;
        end
      end
    end
  end

  // Watchdog for a block that hangs or never finishes a solve.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_entry(int row, int col, int value, bit last);
    entry_t e;
    e.row = jes_pkg::IDX_W'(row);
    e.col = jes_pkg::IDX_W'(col);
    e.value = value;
    e.last = last;
    pending_entries.push_back(e);
  endtask

  // Returns once every item has been taken, every result has arrived and the
  // block has then been given time to settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_entries.size() != 0 || start || busy || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle, so the shadow copy
  // can be updated right away.
  task automatic write_reg(logic [jes_pkg::CFG_IDX_W-1:0] idx,
                           logic [jes_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == jes_pkg::REG_THRESHOLD) shadow_threshold = data;
    else if (idx == jes_pkg::REG_SWEEP_LIMIT) shadow_sweep_limit = data[jes_pkg::LIM_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly values of a few units, sometimes full range or the extremes.
  function automatic int pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return ($urandom_range(0, 1) == 0) ? 32'sh7fffffff : 32'sh80000000;
      2: return 0;
      default: return int'($urandom_range(0, 524288)) - 262144;
    endcase
  endfunction

  function automatic logic [jes_pkg::THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'd1;
      2: return 32'hffffffff;
      3: return $urandom;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  initial begin
    int v;
    int k;
    rst_n = 1'b0;
    start = 1'b0;
    in_entry_row = '0;
    in_entry_col = '0;
    in_entry_value = '0;
    in_last_entry = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    random_sent = 0;
    shadow_threshold = jes_pkg::THRESHOLD_RESET;
    shadow_sweep_limit = jes_pkg::SWEEP_LIMIT_RESET;
    foreach (shadow_matrix[i]) shadow_matrix[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every entry is written before the first solve, so the block never
    // reads an entry it has not been given. Reset register values apply.
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c <= r; c++) begin
        v = int'($urandom_range(0, 262144)) - 131072;
        send_entry(r, c, v, 1'b0);
        if (r != c) send_entry(c, r, v, 1'b0);
      end
    end
    send_entry(N - 1, N - 1, 32'sh00020000, 1'b1);
    wait_idle();

    // No sweep allowed: converged only reports whether the bound already holds.
    write_reg(jes_pkg::REG_THRESHOLD, 32'd0);
    write_reg(jes_pkg::REG_SWEEP_LIMIT, 32'd0);
    send_entry(0, 0, 32'sh7fffffff, 1'b1);
    wait_idle();

    // Largest bound and one sweep, with the most negative value off the diagonal.
    write_reg(jes_pkg::REG_THRESHOLD, 32'hffffffff);
    write_reg(jes_pkg::REG_SWEEP_LIMIT, 32'd1);
    send_entry(1, 0, 32'sh80000000, 1'b0);
    send_entry(0, 1, 32'sh80000000, 1'b1);
    wait_idle();

    // Extreme values actually rotated, which takes the pre-shift path.
    write_reg(jes_pkg::REG_THRESHOLD, 32'd1);
    write_reg(jes_pkg::REG_SWEEP_LIMIT, 32'd16);
    send_entry(1, 1, 32'sh80000000, 1'b0);
    send_entry(2, 0, 32'sh7fffffff, 1'b0);
    send_entry(0, 2, 32'sh7fffffff, 1'b1);
    // An out-of-range last entry is dropped but still starts the solve.
    send_entry(7, 5, $urandom, 1'b1);
    send_entry(3, 7, $urandom, 1'b0);
    // Zero pivots, then a matrix that is no longer symmetric.
    send_entry(1, 0, 0, 1'b0);
    send_entry(0, 1, 0, 1'b0);
    send_entry(2, 0, 0, 1'b0);
    send_entry(0, 2, 0, 1'b0);
    send_entry(1, 1, 32'sh00010000, 1'b1);
    send_entry(3, 2, 32'sh00030000, 1'b1);
    wait_idle();

    // Exact zero bound with the largest sweep count.
    write_reg(jes_pkg::REG_THRESHOLD, 32'd0);
    write_reg(jes_pkg::REG_SWEEP_LIMIT, 32'd255);
    send_entry(2, 1, 32'sh00008000, 1'b0);
    send_entry(1, 2, 32'sh00008000, 1'b1);
    wait_idle();
    write_reg(jes_pkg::REG_THRESHOLD, 32'd1);
    write_reg(jes_pkg::REG_SWEEP_LIMIT, 32'd4);

    // Random phases: mostly symmetric pair updates ending in a solve, with
    // occasional lopsided writes and out-of-range noise. Sweep counts stay
    // small to keep the run short.
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        write_reg(jes_pkg::REG_THRESHOLD, pick_threshold());
        write_reg(jes_pkg::REG_SWEEP_LIMIT,
                  ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 6));
      end
      k = $urandom_range(1, 6);
      for (int j = 0; j < k; j++) begin
        int r;
        int c;
        r = $urandom_range(0, N - 1);
        c = $urandom_range(0, N - 1);
        v = pick_value();
        send_entry(r, c, v, 1'b0);
        random_sent++;
        if (r != c) begin
          send_entry(c, r, ($urandom_range(0, 6) == 0) ? pick_value() : v, 1'b0);
          random_sent++;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_entry($urandom_range(N, 7), $urandom_range(0, 7), $urandom, 1'b0);
          random_sent++;
        end
      end
      if ($urandom_range(0, 4) == 0)
        send_entry($urandom_range(0, 7), $urandom_range(N, 7), $urandom, 1'b1);
      else
        send_entry($urandom_range(0, N - 1), $urandom_range(0, N - 1), pick_value(), 1'b1);
      random_sent++;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
